// File: design/cad_pkg.sv
// Shared types and constants for the channel average decimator.
// Used by cad_front, cad_fifo, cad_back and channel_average_decimator.
`timescale 1ns / 1ps

package cad_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = 22;
	localparam int POL_W        = 2;
	localparam int PCNT_W       = 3;
	localparam int CH_W         = 12;
	localparam int OCH_W        = 13;
	localparam int STEP_W       = 7;
	localparam int PHASE_W      = 6;
	localparam int MAX_POL      = 4;
	localparam int MAX_STEP     = 64;
	localparam int MAX_CHANNELS = 4096;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = 2;
	localparam int DIV_CNT_W    = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_CHANNEL = 3'd0,
		REG_STEP_SIZE     = 3'd1,
		REG_OUT_CHANNELS  = 3'd2,
		REG_AVERAGE_MODE  = 3'd3,
		REG_POL_COUNT     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0]   start_channel;
		logic [STEP_W-1:0] step_size;
		logic [OCH_W-1:0]  out_channels;
		logic              average_mode;
		logic [PCNT_W-1:0] pol_count;
	} cfg_t;

	// One request from the front end to the back end
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_re;
		logic signed [SUM_W-1:0] sum_im;
		logic                    flag;
		logic [POL_W-1:0]        pol;
		logic [CH_W-1:0]         channel;
		logic                    row_last;
		logic                    div;
		logic [STEP_W-1:0]       step;
	} req_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_DIV  = 1'b1
	} b_state_t;

endpackage

// File: design/cad_front.sv
// Front end: accepts samples, tracks row position and accumulates groups.
// Emits one request per result into the queue. Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_front import cad_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample_real,
	input  logic signed [SAMPLE_W-1:0] sample_imag,
	input  logic                       sample_flag,
	input  logic                       row_end,
	input  logic                       q_full,
	output logic                       q_push,
	output req_t                       q_req
);

	logic [POL_W-1:0]        pol_q;
	logic [CH_W-1:0]         in_ch_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [OCH_W-1:0]        och_q;
	logic signed [SUM_W-1:0] sum_re_q [MAX_POL];
	logic signed [SUM_W-1:0] sum_im_q [MAX_POL];
	logic [MAX_POL-1:0]      flag_or_q;

	logic [STEP_W-1:0]       step_c;
	logic [PCNT_W-1:0]       npol_c;
	logic [OCH_W-1:0]        nout_c;
	logic [POL_W-1:0]        p_eff;
	logic                    last_pol;
	logic                    started;
	logic                    active;
	logic                    group_end;
	logic                    first;
	logic                    emit;
	logic                    accept;
	logic signed [SUM_W-1:0] ext_re;
	logic signed [SUM_W-1:0] ext_im;
	logic signed [SUM_W-1:0] acc_re;
	logic signed [SUM_W-1:0] acc_im;
	logic                    acc_flag;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		// clamp registers to their legal ranges
		if (cfg.step_size == '0) begin
			step_c = STEP_W'(1);
		end else if (cfg.step_size > STEP_W'(MAX_STEP)) begin
			step_c = STEP_W'(MAX_STEP);
		end else begin
			step_c = cfg.step_size;
		end
		if (cfg.pol_count == '0) begin
			npol_c = PCNT_W'(1);
		end else if (cfg.pol_count > PCNT_W'(MAX_POL)) begin
			npol_c = PCNT_W'(MAX_POL);
		end else begin
			npol_c = cfg.pol_count;
		end
		if (cfg.out_channels == '0) begin
			nout_c = OCH_W'(1);
		end else if (cfg.out_channels > OCH_W'(MAX_CHANNELS)) begin
			nout_c = OCH_W'(MAX_CHANNELS);
		end else begin
			nout_c = cfg.out_channels;
		end
	end

	always_comb begin
		// a stale polarization index counts as the last one
		if (PCNT_W'(pol_q) >= npol_c) begin
			p_eff = POL_W'(npol_c - PCNT_W'(1));
		end else begin
			p_eff = pol_q;
		end
		last_pol  = (PCNT_W'(p_eff) + PCNT_W'(1)) >= npol_c;
		started   = in_ch_q >= cfg.start_channel;
		active    = started && (och_q < nout_c);
		group_end = (STEP_W'(phase_q) + STEP_W'(1)) >= step_c;
		first     = phase_q == '0;
		ext_re    = {{(SUM_W-SAMPLE_W){sample_real[SAMPLE_W-1]}}, sample_real};
		ext_im    = {{(SUM_W-SAMPLE_W){sample_imag[SAMPLE_W-1]}}, sample_imag};
		acc_re    = first ? ext_re : sum_re_q[p_eff] + ext_re;
		acc_im    = first ? ext_im : sum_im_q[p_eff] + ext_im;
		acc_flag  = first ? sample_flag : (flag_or_q[p_eff] | sample_flag);
		emit      = active && (cfg.average_mode ? group_end : first);
	end

	always_comb begin
		q_req.sum_re   = cfg.average_mode ? acc_re : ext_re;
		q_req.sum_im   = cfg.average_mode ? acc_im : ext_im;
		q_req.flag     = cfg.average_mode ? acc_flag : sample_flag;
		q_req.pol      = p_eff;
		q_req.channel  = och_q[CH_W-1:0];
		q_req.row_last = ((och_q + OCH_W'(1)) == nout_c) && last_pol;
		q_req.div      = cfg.average_mode;
		q_req.step     = step_c;
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q     <= '0;
			in_ch_q   <= '0;
			phase_q   <= '0;
			och_q     <= '0;
			flag_or_q <= '0;
			for (int i = 0; i < MAX_POL; i++) begin
				sum_re_q[i] <= '0;
				sum_im_q[i] <= '0;
			end
		end else if (accept) begin
			if (row_end) begin
				// restart the row, drop any partial group
				pol_q     <= '0;
				in_ch_q   <= '0;
				phase_q   <= '0;
				och_q     <= '0;
				flag_or_q <= '0;
				for (int i = 0; i < MAX_POL; i++) begin
					sum_re_q[i] <= '0;
					sum_im_q[i] <= '0;
				end
			end else begin
				if (cfg.average_mode && active) begin
					sum_re_q[p_eff]  <= acc_re;
					sum_im_q[p_eff]  <= acc_im;
					flag_or_q[p_eff] <= acc_flag;
				end
				if (last_pol) begin
					pol_q <= '0;
					if (!started) begin
						in_ch_q <= in_ch_q + CH_W'(1);
					end else if (active) begin
						if (group_end) begin
							phase_q <= '0;
							och_q   <= och_q + OCH_W'(1);
						end else begin
							phase_q <= phase_q + PHASE_W'(1);
						end
					end
				end else begin
					pol_q <= p_eff + POL_W'(1);
				end
			end
		end
	end

endmodule

// File: design/cad_fifo.sv
// Short request queue between the front end and the back end.
// Depends on cad_pkg for req_t and the queue depth.
`timescale 1ns / 1ps

module cad_fifo import cad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  req_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output req_t rd_data,
	output logic q_empty
);

	req_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    count_q;

	assign q_full  = count_q == (Q_AW+1)'(Q_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/cad_back.sv
// Back end: takes requests from the queue, divides group sums by the step
// one quotient bit a cycle, and holds the result register. Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_back import cad_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  req_t                       q_req,
	output logic                       q_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] out_real,
	output logic signed [SAMPLE_W-1:0] out_imag,
	output logic                       out_flag,
	output logic [POL_W-1:0]           out_pol,
	output logic [CH_W-1:0]            out_channel,
	output logic                       row_last
);

	b_state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]      rem_re_q, rem_im_q;
	logic [SUM_W-1:0]       dq_re_q, dq_im_q;
	logic                   neg_re_q, neg_im_q;
	req_t                   hold_q;
	logic                   out_valid_q;

	logic                   slot_free;
	logic                   load_out;
	logic                   start_div;
	logic [STEP_W+1:0]      diff_re, diff_im;
	logic [STEP_W:0]        part_re, part_im;
	logic                   ge_re, ge_im;
	logic [SAMPLE_W-1:0]    qmag_re, qmag_im;
	logic [SAMPLE_W-1:0]    res_re, res_im;
	logic [SUM_W-1:0]       mag_re, mag_im;

	assign slot_free = !out_valid_q || pop;
	assign empty     = !out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && q_req.div) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == '0 && slot_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		start_div = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			B_IDLE: begin
				start_div = !q_empty && q_req.div;
				q_pop     = !q_empty && (q_req.div || slot_free);
				load_out  = !q_empty && !q_req.div && slot_free;
			end
			B_DIV: begin
				load_out = (cnt_q == '0) && slot_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		// restoring division step on both parts
		part_re = {rem_re_q, dq_re_q[SUM_W-1]};
		part_im = {rem_im_q, dq_im_q[SUM_W-1]};
		diff_re = {1'b0, part_re} - (STEP_W+2)'(hold_q.step);
		diff_im = {1'b0, part_im} - (STEP_W+2)'(hold_q.step);
		ge_re   = !diff_re[STEP_W+1];
		ge_im   = !diff_im[STEP_W+1];
		mag_re  = q_req.sum_re[SUM_W-1] ? SUM_W'(-q_req.sum_re) : SUM_W'(q_req.sum_re);
		mag_im  = q_req.sum_im[SUM_W-1] ? SUM_W'(-q_req.sum_im) : SUM_W'(q_req.sum_im);
		qmag_re = dq_re_q[SAMPLE_W-1:0];
		qmag_im = dq_im_q[SAMPLE_W-1:0];
		if (state_q == B_DIV) begin
			res_re = neg_re_q ? SAMPLE_W'(-qmag_re) : qmag_re;
			res_im = neg_im_q ? SAMPLE_W'(-qmag_im) : qmag_im;
		end else begin
			res_re = q_req.sum_re[SAMPLE_W-1:0];
			res_im = q_req.sum_im[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_div) begin
				cnt_q <= DIV_CNT_W'(SUM_W);
			end else if (state_q == B_DIV && cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			hold_q   <= q_req;
			rem_re_q <= '0;
			rem_im_q <= '0;
			dq_re_q  <= mag_re;
			dq_im_q  <= mag_im;
			neg_re_q <= q_req.sum_re[SUM_W-1];
			neg_im_q <= q_req.sum_im[SUM_W-1];
		end else if (state_q == B_DIV && cnt_q != '0) begin
			rem_re_q <= ge_re ? diff_re[STEP_W-1:0] : part_re[STEP_W-1:0];
			rem_im_q <= ge_im ? diff_im[STEP_W-1:0] : part_im[STEP_W-1:0];
			dq_re_q  <= {dq_re_q[SUM_W-2:0], ge_re};
			dq_im_q  <= {dq_im_q[SUM_W-2:0], ge_im};
		end
		if (load_out) begin
			out_real    <= res_re;
			out_imag    <= res_im;
			if (state_q == B_DIV) begin
				out_flag    <= hold_q.flag;
				out_pol     <= hold_q.pol;
				out_channel <= hold_q.channel;
				row_last    <= hold_q.row_last;
			end else begin
				out_flag    <= q_req.flag;
				out_pol     <= q_req.pol;
				out_channel <= q_req.channel;
				row_last    <= q_req.row_last;
			end
		end
	end

endmodule

// File: design/channel_average_decimator.sv
// Channel average decimator: per-row boxcar average or pick-first decimation
// of complex samples; a front end feeds a four-entry queue and a back end that
// holds the divider and the result register. In select mode one sample is
// taken every cycle while the queue is not full. In average mode the back end's
// bit-serial divider works out 22 quotient bits for each result and takes no new
// request from the queue while a division is in progress, so for small step_size
// the divider sets the rate and the queue absorbs short bursts.
// Depends on cad_pkg, cad_front, cad_fifo and cad_back.
`timescale 1ns / 1ps

module channel_average_decimator import cad_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample_real,
	input  logic signed [SAMPLE_W-1:0] sample_imag,
	input  logic                       sample_flag,
	input  logic                       row_end,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] out_real,
	output logic signed [SAMPLE_W-1:0] out_imag,
	output logic                       out_flag,
	output logic [POL_W-1:0]           out_pol,
	output logic [CH_W-1:0]            out_channel,
	output logic                       row_last
);

	cfg_t cfg_q;
	logic q_push, q_pop, q_full, q_empty;
	req_t q_wr_req, q_rd_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_channel <= '0;
			cfg_q.step_size     <= STEP_W'(1);
			cfg_q.out_channels  <= OCH_W'(1);
			cfg_q.average_mode  <= 1'b0;
			cfg_q.pol_count     <= PCNT_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_CHANNEL: cfg_q.start_channel <= cfg_data[CH_W-1:0];
				REG_STEP_SIZE:     cfg_q.step_size     <= cfg_data[STEP_W-1:0];
				REG_OUT_CHANNELS:  cfg_q.out_channels  <= cfg_data[OCH_W-1:0];
				REG_AVERAGE_MODE:  cfg_q.average_mode  <= cfg_data[0];
				REG_POL_COUNT:     cfg_q.pol_count     <= cfg_data[PCNT_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	cad_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.sample_flag (sample_flag),
		.row_end     (row_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_req       (q_wr_req)
	);

	cad_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_req),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_req),
		.q_empty (q_empty)
	);

	cad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_req       (q_rd_req),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_real    (out_real),
		.out_imag    (out_imag),
		.out_flag    (out_flag),
		.out_pol     (out_pol),
		.out_channel (out_channel),
		.row_last    (row_last)
	);

`ifndef SYNTHESIS
	// front end never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("request written into full queue");

	// back end never reads an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("request read from empty queue");

	// a request written without a read leaves the queue occupied
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty) else $error("queue lost a request");
`endif

endmodule

// File: dv/tb_channel_average_decimator.sv
// Self-checking testbench for channel_average_decimator: directed table, then random rows.
// Depends on cad_pkg and the channel_average_decimator RTL; everything else is local.
`timescale 1ns / 1ps

module tb_channel_average_decimator;
	import cad_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET   = 1450;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       flag;
		logic [POL_W-1:0]           pol;
		logic [CH_W-1:0]            chan;
		logic                       row_last;
	} dec_result_t;

	typedef enum bit {ROW_REG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		reg_idx_t                   idx;
		int unsigned                data;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       fl;
		logic                       rend;
		bit                         typed;
		dec_result_t                want;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       push;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample_real;
	logic signed [SAMPLE_W-1:0] sample_imag;
	logic                       sample_flag;
	logic                       row_end;
	logic                       empty;
	logic                       pop;
	logic signed [SAMPLE_W-1:0] out_real;
	logic signed [SAMPLE_W-1:0] out_imag;
	logic                       out_flag;
	logic [POL_W-1:0]           out_pol;
	logic [CH_W-1:0]            out_channel;
	logic                       row_last;

	channel_average_decimator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.sample_flag (sample_flag),
		.row_end     (row_end),
		.empty       (empty),
		.pop         (pop),
		.out_real    (out_real),
		.out_imag    (out_imag),
		.out_flag    (out_flag),
		.out_pol     (out_pol),
		.out_channel (out_channel),
		.row_last    (row_last)
	);

	// Register copies and row counters of the decimation predictor
	logic [CH_W-1:0]   reg_start = '0;
	logic [STEP_W-1:0] reg_step  = STEP_W'(1);
	logic [OCH_W-1:0]  reg_nout  = OCH_W'(1);
	logic              reg_avg   = 1'b0;
	logic [PCNT_W-1:0] reg_npol  = PCNT_W'(1);
	logic [POL_W-1:0]  row_pol    = '0;
	logic [CH_W-1:0]   row_in_ch  = '0;
	logic [PHASE_W-1:0] row_phase = '0;
	logic [OCH_W-1:0]  row_out_ch = '0;
	longint            acc_re [MAX_POL] = '{default: 0};
	longint            acc_im [MAX_POL] = '{default: 0};
	logic              acc_flag [MAX_POL] = '{default: 1'b0};

	dec_result_t pending_results[$];
	dec_result_t typed_result;
	bit          typed_valid = 1'b0;
	bit          calm = 1'b0;
	int          mismatches = 0;
	int          accepted_items = 0;
	int          used_items = 0;
	int          checked_results = 0;
	int          settings_run = 0;
	int          cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Cycle limit hit with %0d results outstanding", pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		case (reg_idx_t'(idx))
			REG_START_CHANNEL: reg_start = d[CH_W-1:0];
			REG_STEP_SIZE:     reg_step  = d[STEP_W-1:0];
			REG_OUT_CHANNELS:  reg_nout  = d[OCH_W-1:0];
			REG_AVERAGE_MODE:  reg_avg   = d[0];
			REG_POL_COUNT:     reg_npol  = d[PCNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the row counters by one sample; returns 1 when the sample yields a result
	function automatic bit decimate_sample(input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im, input logic fl, input logic rend,
		output bit used, output dec_result_t r);
		int unsigned step_n, pol_n, out_n, p;
		bit started, grp_end, last_pol, emit;
		longint ore, oim;
		logic ofl;
		step_n = (reg_step == 0) ? 1 : ((reg_step > MAX_STEP) ? MAX_STEP : reg_step);
		pol_n = (reg_npol == 0) ? 1 : ((reg_npol > MAX_POL) ? MAX_POL : reg_npol);
		out_n = (reg_nout == 0) ? 1 : ((reg_nout > MAX_CHANNELS) ? MAX_CHANNELS : reg_nout);
		p = row_pol;
		started = row_in_ch >= reg_start;
		used = started && (row_out_ch < out_n);
		grp_end = (row_phase + 1) >= step_n;
		// a polarization counter left beyond a lowered pol_count acts as the last one
		if (p >= pol_n)
			p = pol_n - 1;
		last_pol = (p + 1) >= pol_n;
		emit = 1'b0;
		ore = longint'(re);
		oim = longint'(im);
		ofl = fl;
		if (used) begin
			if (reg_avg) begin
				if (row_phase == 0) begin
					acc_re[p] = longint'(re);
					acc_im[p] = longint'(im);
					acc_flag[p] = fl;
				end else begin
					acc_re[p] += longint'(re);
					acc_im[p] += longint'(im);
					acc_flag[p] |= fl;
				end
				if (grp_end) begin
					emit = 1'b1;
					ore = acc_re[p] / longint'(step_n);
					oim = acc_im[p] / longint'(step_n);
					ofl = acc_flag[p];
				end
			end else begin
				emit = (row_phase == 0);
			end
		end
		r.re = ore[SAMPLE_W-1:0];
		r.im = oim[SAMPLE_W-1:0];
		r.flag = ofl;
		r.pol = p[POL_W-1:0];
		r.chan = row_out_ch[CH_W-1:0];
		r.row_last = ((row_out_ch + 1) == out_n) && last_pol;
		if (last_pol) begin
			row_pol = '0;
			if (!started) begin
				row_in_ch = row_in_ch + 1'b1;
			end else if (used) begin
				if (grp_end) begin
					row_phase = '0;
					row_out_ch = row_out_ch + 1'b1;
				end else begin
					row_phase = row_phase + 1'b1;
				end
			end
		end else begin
			row_pol = p[POL_W-1:0] + 1'b1;
		end
		// row end drops any partial group
		if (rend) begin
			row_pol = '0;
			row_in_ch = '0;
			row_phase = '0;
			row_out_ch = '0;
			foreach (acc_re[i]) begin
				acc_re[i] = 0;
				acc_im[i] = 0;
				acc_flag[i] = 1'b0;
			end
		end
		return emit;
	endfunction

	// Outputs and inputs only change at rising edges, so sample both sides at the falling edge
	always @(negedge clk) begin
		dec_result_t got, want, pred;
		bit produced, used;
		if (arst_n) begin
			if (cfg_wr_en)
				load_reg(cfg_index, cfg_data);
			if (pop && !empty) begin
				got = '{out_real, out_imag, out_flag, out_pol, out_channel, row_last};
				if (pending_results.size() == 0) begin
					report_mismatch("out_channel of a result nobody expects", got.chan, -1);
				end else begin
					want = pending_results.pop_front();
					checked_results++;
					if (got.re !== want.re) report_mismatch("out_real", got.re, want.re);
					if (got.im !== want.im) report_mismatch("out_imag", got.im, want.im);
					if (got.flag !== want.flag) report_mismatch("out_flag", got.flag, want.flag);
					if (got.pol !== want.pol) report_mismatch("out_pol", got.pol, want.pol);
					if (got.chan !== want.chan) report_mismatch("out_channel", got.chan, want.chan);
					if (got.row_last !== want.row_last)
						report_mismatch("row_last", got.row_last, want.row_last);
				end
			end
			if (push && !full) begin
				produced = decimate_sample(sample_real, sample_imag, sample_flag, row_end,
					used, pred);
				accepted_items++;
				if (used)
					used_items++;
				if (typed_valid)
					pending_results.push_back(typed_result);
				else if (produced)
					pending_results.push_back(pred);
			end
		end
	end

	// Receiver: pop stalls about one cycle in five outside the calm stretch
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			pop <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	function automatic int idle_cycles();
		int n;
		n = 0;
		if (!calm)
			while ($urandom_range(0, 99) < 20)
				n++;
		return n;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im, input logic fl, input logic rend,
		input bit typed, input dec_result_t want);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample_real <= re;
		sample_imag <= im;
		sample_flag <= fl;
		row_end <= rend;
		typed_valid = typed;
		typed_result = want;
		forever begin
			@(negedge clk);
			if (!full)
				break;
		end
		@(posedge clk);
	endtask

	task automatic send_row(input int unsigned n, input bit close);
		for (int unsigned i = 0; i < n; i++)
			send_sample(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
				close && (i == n - 1), 1'b0, '0);
	endtask

	// Hold the sender until every result is out, then let the pipeline run dry
	task automatic settle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned start_v, input int unsigned step_v,
		input int unsigned nout_v, input int unsigned avg_v, input int unsigned npol_v,
		input int unsigned nrows, input bit whole);
		int unsigned step_n, pol_n, out_n, row_len, n, cut;
		int kind;
		settle();
		write_reg(REG_START_CHANNEL, start_v);
		write_reg(REG_STEP_SIZE, step_v);
		write_reg(REG_OUT_CHANNELS, nout_v);
		write_reg(REG_AVERAGE_MODE, avg_v);
		write_reg(REG_POL_COUNT, npol_v);
		cfg_wr_en <= 1'b0;
		settings_run++;
		step_n = (step_v == 0) ? 1 : ((step_v > MAX_STEP) ? MAX_STEP : step_v);
		pol_n = (npol_v == 0) ? 1 : ((npol_v > MAX_POL) ? MAX_POL : npol_v);
		out_n = (nout_v == 0) ? 1 : ((nout_v > MAX_CHANNELS) ? MAX_CHANNELS : nout_v);
		row_len = (start_v + step_n * out_n) * pol_n;
		for (int unsigned r = 0; r < nrows; r++) begin
			kind = $urandom_range(0, 9);
			if (whole)
				n = row_len;
			else if (row_len > 400)
				n = $urandom_range(1, 120);
			else if (kind == 0)
				n = $urandom_range(1, row_len);
			else if (kind == 1)
				n = row_len + $urandom_range(1, 2 * pol_n);
			else
				n = row_len;
			if (kind == 2 && !whole && row_len <= 400) begin
				// stop mid-row, change pol_count or step_size while idle, then finish the row
				cut = $urandom_range(1, n);
				send_row(cut, 1'b0);
				settle();
				if ($urandom_range(0, 1))
					write_reg(REG_POL_COUNT, $urandom_range(1, 4));
				else
					write_reg(REG_STEP_SIZE, $urandom_range(1, 6));
				cfg_wr_en <= 1'b0;
				send_row($urandom_range(1, row_len), 1'b1);
				break;
			end
			send_row(n, 1'b1);
		end
	endtask

	initial begin
		dir_row_t plan[$];
		bit cfg_open;
		int phase_no;
		int unsigned x_start, x_step, x_nout, x_npol;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_START_CHANNEL;
		cfg_data = '0;
		push = 1'b0;
		sample_real = '0;
		sample_imag = '0;
		sample_flag = 1'b0;
		row_end = 1'b0;

		// Reset settings: select mode, one pol, one output channel
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0,
			1'b1, '{16'sh7FFF, 16'sh8000, 1'b1, 2'd0, 12'd0, 1'b1}});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, -16'sd1, 16'sd1, 1'b0, 1'b1,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd0, 16'sd0, 1'b0, 1'b1,
			1'b1, '{16'sd0, 16'sd0, 1'b0, 2'd0, 12'd0, 1'b1}});
		// Average two channels of two pols: extremes, flag OR, truncation toward zero
		plan.push_back('{ROW_REG, REG_POL_COUNT, 2, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_OUT_CHANNELS, 2, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_AVERAGE_MODE, 1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_STEP_SIZE, 2, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sh8000, 16'sh8000, 1'b1, 1'b0,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0,
			1'b1, '{16'sh7FFF, 16'sh7FFF, 1'b0, 2'd0, 12'd0, 1'b0}});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sh8000, 16'sh8000, 1'b0, 1'b0,
			1'b1, '{16'sh8000, 16'sh8000, 1'b1, 2'd1, 12'd0, 1'b0}});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, -16'sd3, 16'sd3, 1'b0, 1'b0,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd1, -16'sd1, 1'b1, 1'b0,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd0, 16'sd0, 1'b0, 1'b0,
			1'b1, '{-16'sd1, 16'sd1, 1'b0, 2'd0, 12'd1, 1'b0}});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd0, 16'sd0, 1'b0, 1'b1,
			1'b1, '{16'sd0, 16'sd0, 1'b1, 2'd1, 12'd1, 1'b1}});
		// Zero registers act as one
		plan.push_back('{ROW_REG, REG_STEP_SIZE, 0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_POL_COUNT, 0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_OUT_CHANNELS, 0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd5, -16'sd5, 1'b1, 1'b1,
			1'b1, '{16'sd5, -16'sd5, 1'b1, 2'd0, 12'd0, 1'b1}});
		// Oversized registers clamp; skipped channels give nothing
		plan.push_back('{ROW_REG, REG_STEP_SIZE, 127, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_POL_COUNT, 7, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_REG, REG_OUT_CHANNELS, 8191, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0,
			'0});
		plan.push_back('{ROW_REG, REG_START_CHANNEL, 3, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd100, -16'sd100, 1'b0, 1'b0,
			1'b0, '0});
		plan.push_back('{ROW_SAMPLE, REG_START_CHANNEL, 0, 16'sd7, 16'sd7, 1'b1, 1'b1,
			1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		cfg_open = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (!cfg_open)
					settle();
				write_reg(plan[i].idx, plan[i].data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_wr_en <= 1'b0;
					cfg_open = 1'b0;
				end
				send_sample(plan[i].re, plan[i].im, plan[i].fl, plan[i].rend, plan[i].typed,
					plan[i].want);
			end
		end

		// Skip a long run of start channels in full, then one whole row of 64-channel averages
		run_phase(255, 1, 2, 0, 1, 1, 1'b1);
		run_phase(0, 64, 2, 1, 2, 1, 1'b1);

		phase_no = 0;
		while (accepted_items < ITEM_TARGET) begin
			calm = (phase_no >= 3 && phase_no < 8);
			if ($urandom_range(0, 7) == 0) begin
				x_start = $urandom_range(0, 1) ? 0 : 4095;
				case ($urandom_range(0, 3))
					0: x_step = 0;
					1: x_step = 64;
					2: x_step = 127;
					default: x_step = $urandom_range(65, 126);
				endcase
				case ($urandom_range(0, 3))
					0: x_nout = 0;
					1: x_nout = 1;
					2: x_nout = 4096;
					default: x_nout = 8191;
				endcase
				x_npol = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(4, 7);
				run_phase(x_start, x_step, x_nout, $urandom_range(0, 1), x_npol,
					$urandom_range(1, 3), 1'b0);
			end else begin
				run_phase($urandom_range(0, 1) ? 0 : $urandom_range(1, 3), $urandom_range(1, 6),
					$urandom_range(1, 5), $urandom_range(0, 1), $urandom_range(1, 4),
					$urandom_range(1, 4), 1'b0);
			end
			phase_no++;
		end
		calm = 1'b0;
		settle();

		$display("Sent %0d samples (%0d inside the output window) under %0d register settings",
			accepted_items, used_items, settings_run);
		$display("Checked %0d results; select and average modes, skips, cut and long rows",
			checked_results);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
